// ----- design/integer_matrix_multiply_assert.svh -----
// Assertion macros shared by the matrix multiplier modules.
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef INTEGER_MATRIX_MULTIPLY_ASSERT_SVH
`define INTEGER_MATRIX_MULTIPLY_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle property, checked outside reset.
`define IMM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Next-cycle implication, checked outside reset.
`define IMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define IMM_ASSERT(lbl, clk, rst_n, prop, msg)
`define IMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- design/imm_pkg.sv -----
package imm_pkg;

    localparam int MAX_DIM    = 8;
    localparam int DATA_W     = 32;
    localparam int DIM_W      = 4;                     // configuration register width
    localparam int IDX_W      = $clog2(MAX_DIM);       // row / column / inner index
    localparam int DEPTH      = MAX_DIM * MAX_DIM;     // entries per matrix store
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = ADDR_W + 1;            // load counter over A and B
    localparam int LEN_W      = CNT_W + 1;             // room for a full run length
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic              wr_a;
        logic              wr_b;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] a_addr;
        logic [ADDR_W-1:0] b_addr;
        logic              first;
        logic              last;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic              last_run;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_busy;
        logic done;
    } t_stat;

    // Clamp a dimension register to 1..MAX_DIM and return it minus one
    function automatic logic [IDX_W-1:0] eff_dim_m1(input logic [DIM_W-1:0] v);
        logic [IDX_W-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (v > DIM_W'(MAX_DIM)) begin
            res = IDX_W'(MAX_DIM - 1);
        end else begin
            res = IDX_W'(v - DIM_W'(1));
        end
        return res;
    endfunction

endpackage

// ----- design/integer_matrix_multiply.sv -----
// Integer matrix multiplier: set rows_a, inner_dim and cols_b (register indexes 0, 1, 2;
// 0 reads as 1, above 8 reads as 8; a write to any of them restarts loading), then send A and B
// row-major, one element per transaction, A first. Loading accepts one element per cycle.
// After the last B element the product comes out row-major with row, column and a last
// mark; each product element is computed by the single shared multiply-accumulate
// fed from one read port on each store: inner_dim issue steps, then the read and
// multiply stages; the next dot product is not issued while the output register
// still holds a result that the receiver has not taken. Sums wrap modulo 2^32.
// Loading of the next run may start while the final result still waits in the
// output register.
module integer_matrix_multiply (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [imm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [imm_pkg::DIM_W-1:0]          i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [imm_pkg::DATA_W-1:0]  i_element,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [imm_pkg::DATA_W-1:0]  o_product_value,
    output logic [imm_pkg::IDX_W-1:0]          o_out_row,
    output logic [imm_pkg::IDX_W-1:0]          o_out_col,
    output logic                               o_last_of_run
);

    imm_pkg::t_cmd  cmd;
    imm_pkg::t_stat stat;

    // Sequencer
    imm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Stores, multiply-accumulate and output register
    imm_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_element       (i_element),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_product_value (o_product_value),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

// ----- design/imm_ctrl.sv -----
`include "integer_matrix_multiply_assert.svh"

module imm_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [imm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [imm_pkg::DIM_W-1:0]        i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  imm_pkg::t_stat                   i_stat,
    output imm_pkg::t_cmd                    o_cmd
);

    typedef enum logic [2:0] {
        S_LOAD  = 3'b001,
        S_ISSUE = 3'b010,
        S_WAIT  = 3'b100
    } t_state;

    t_state                          r_state, n_state;
    logic [imm_pkg::CNT_W-1:0]       r_load_cnt, n_load_cnt;
    logic [imm_pkg::IDX_W-1:0]       r_rm1, n_rm1;
    logic [imm_pkg::IDX_W-1:0]       r_km1, n_km1;
    logic [imm_pkg::IDX_W-1:0]       r_cm1, n_cm1;
    logic [imm_pkg::IDX_W-1:0]       r_i, n_i;
    logic [imm_pkg::IDX_W-1:0]       r_j, n_j;
    logic [imm_pkg::IDX_W-1:0]       r_t, n_t;
    logic [imm_pkg::ADDR_W-1:0]      r_a_base, n_a_base;
    logic [imm_pkg::ADDR_W-1:0]      r_a_addr, n_a_addr;
    logic [imm_pkg::ADDR_W-1:0]      r_b_addr, n_b_addr;

    logic [imm_pkg::DIM_W-1:0]       dim_r, dim_k, dim_c;
    logic [imm_pkg::CNT_W-1:0]       a_len, b_len;
    logic [imm_pkg::LEN_W-1:0]       total_m1;
    logic                            accept, last_load, in_a, issue;

    // Effective dimensions and run lengths
    assign dim_r    = imm_pkg::DIM_W'(r_rm1) + imm_pkg::DIM_W'(1);
    assign dim_k    = imm_pkg::DIM_W'(r_km1) + imm_pkg::DIM_W'(1);
    assign dim_c    = imm_pkg::DIM_W'(r_cm1) + imm_pkg::DIM_W'(1);
    assign a_len    = imm_pkg::CNT_W'(dim_r) * imm_pkg::CNT_W'(dim_k);
    assign b_len    = imm_pkg::CNT_W'(dim_k) * imm_pkg::CNT_W'(dim_c);
    assign total_m1 = imm_pkg::LEN_W'(a_len) + imm_pkg::LEN_W'(b_len)
                      - imm_pkg::LEN_W'(1);

    // Load handshake
    assign o_in_ready = (r_state == S_LOAD);
    assign accept     = i_in_valid && (r_state == S_LOAD);
    assign last_load  = accept && (imm_pkg::LEN_W'(r_load_cnt) == total_m1);
    assign in_a       = (r_load_cnt < a_len);
    assign issue      = (r_state == S_ISSUE) && !i_stat.out_busy;

    // Commands to the datapath
    always_comb begin
        o_cmd          = '0;
        o_cmd.wr_a     = accept && in_a;
        o_cmd.wr_b     = accept && !in_a;
        o_cmd.wr_addr  = in_a ? r_load_cnt[imm_pkg::ADDR_W-1:0]
                              : imm_pkg::ADDR_W'(r_load_cnt - a_len);
        o_cmd.rd_en    = issue;
        o_cmd.a_addr   = r_a_addr;
        o_cmd.b_addr   = r_b_addr;
        o_cmd.first    = (r_t == '0);
        o_cmd.last     = (r_t == r_km1);
        o_cmd.row      = r_i;
        o_cmd.col      = r_j;
        o_cmd.last_run = (r_i == r_rm1) && (r_j == r_cm1);
    end

    // Sequence loading, dot-product issue and result hand-off
    always_comb begin
        n_state    = r_state;
        n_load_cnt = r_load_cnt;
        n_rm1      = r_rm1;
        n_km1      = r_km1;
        n_cm1      = r_cm1;
        n_i        = r_i;
        n_j        = r_j;
        n_t        = r_t;
        n_a_base   = r_a_base;
        n_a_addr   = r_a_addr;
        n_b_addr   = r_b_addr;

        unique case (r_state)
            S_LOAD: begin
                if (last_load) begin
                    n_load_cnt = '0;
                    n_i        = '0;
                    n_j        = '0;
                    n_t        = '0;
                    n_a_base   = '0;
                    n_a_addr   = '0;
                    n_b_addr   = '0;
                    n_state    = S_ISSUE;
                end else if (accept) begin
                    n_load_cnt = r_load_cnt + imm_pkg::CNT_W'(1);
                end
            end
            S_ISSUE: begin
                if (issue) begin
                    if (r_t == r_km1) begin
                        n_t     = '0;
                        n_state = S_WAIT;
                    end else begin
                        n_t      = r_t + imm_pkg::IDX_W'(1);
                        n_a_addr = r_a_addr + imm_pkg::ADDR_W'(1);
                        n_b_addr = r_b_addr + imm_pkg::ADDR_W'(dim_c);
                    end
                end
            end
            S_WAIT: begin
                if (i_stat.done) begin
                    priority if (r_j != r_cm1) begin
                        n_j      = r_j + imm_pkg::IDX_W'(1);
                        n_a_addr = r_a_base;
                        n_b_addr = imm_pkg::ADDR_W'(r_j) + imm_pkg::ADDR_W'(1);
                        n_state  = S_ISSUE;
                    end else if (r_i != r_rm1) begin
                        n_i      = r_i + imm_pkg::IDX_W'(1);
                        n_j      = '0;
                        n_a_base = r_a_base + imm_pkg::ADDR_W'(dim_k);
                        n_a_addr = r_a_base + imm_pkg::ADDR_W'(dim_k);
                        n_b_addr = '0;
                        n_state  = S_ISSUE;
                    end else begin
                        n_state  = S_LOAD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase

        // Writes to the dimension registers restart loading
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                imm_pkg::CFG_ROWS_A: begin
                    n_rm1      = imm_pkg::eff_dim_m1(i_cfg_data);
                    n_load_cnt = '0;
                end
                imm_pkg::CFG_INNER_DIM: begin
                    n_km1      = imm_pkg::eff_dim_m1(i_cfg_data);
                    n_load_cnt = '0;
                end
                imm_pkg::CFG_COLS_B: begin
                    n_cm1      = imm_pkg::eff_dim_m1(i_cfg_data);
                    n_load_cnt = '0;
                end
                default: ;
            endcase
        end
    end

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_load_cnt <= '0;
            r_rm1      <= '0;
            r_km1      <= '0;
            r_cm1      <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_t        <= '0;
            r_a_base   <= '0;
            r_a_addr   <= '0;
            r_b_addr   <= '0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_rm1      <= n_rm1;
            r_km1      <= n_km1;
            r_cm1      <= n_cm1;
            r_i        <= n_i;
            r_j        <= n_j;
            r_t        <= n_t;
            r_a_base   <= n_a_base;
            r_a_addr   <= n_a_addr;
            r_b_addr   <= n_b_addr;
        end
    end

    `IMM_ASSERT(a_done_in_wait, i_clk, i_rst_n, i_stat.done |-> (r_state == S_WAIT), "result completed outside wait")
    `IMM_ASSERT(a_inner_in_range, i_clk, i_rst_n, (r_t <= r_km1), "inner index past inner dimension")
    `IMM_ASSERT(a_rowcol_in_range, i_clk, i_rst_n, (r_state == S_ISSUE) |-> ((r_i <= r_rm1) && (r_j <= r_cm1)), "product index out of range")
    `IMM_ASSERT_NEXT(a_last_load_starts, i_clk, i_rst_n, last_load, (r_state == S_ISSUE), "final element did not start compute")

endmodule

// ----- design/imm_dpath.sv -----
`include "integer_matrix_multiply_assert.svh"

module imm_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  imm_pkg::t_cmd                      i_cmd,
    output imm_pkg::t_stat                     o_stat,
    input  logic signed [imm_pkg::DATA_W-1:0]  i_element,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [imm_pkg::DATA_W-1:0]  o_product_value,
    output logic [imm_pkg::IDX_W-1:0]          o_out_row,
    output logic [imm_pkg::IDX_W-1:0]          o_out_col,
    output logic                               o_last_of_run
);

    logic [imm_pkg::DATA_W-1:0] a_mem [imm_pkg::DEPTH];
    logic [imm_pkg::DATA_W-1:0] b_mem [imm_pkg::DEPTH];

    // Read stage
    logic                        r_p1_valid;
    logic [imm_pkg::DATA_W-1:0]  r_a_q, r_b_q;
    logic                        r_p1_first, r_p1_last, r_p1_last_run;
    logic [imm_pkg::IDX_W-1:0]   r_p1_row, r_p1_col;
    // Multiply stage
    logic                        r_p2_valid;
    logic [imm_pkg::DATA_W-1:0]  r_prod;
    logic                        r_p2_first, r_p2_last, r_p2_last_run;
    logic [imm_pkg::IDX_W-1:0]   r_p2_row, r_p2_col;
    // Accumulator and output register
    logic [imm_pkg::DATA_W-1:0]  r_acc;
    logic [imm_pkg::DATA_W-1:0]  sum;
    logic [imm_pkg::DATA_W-1:0]  prod_low;
    logic                        r_out_valid;
    logic [imm_pkg::DATA_W-1:0]  r_out_value;
    logic [imm_pkg::IDX_W-1:0]   r_out_row, r_out_col;
    logic                        r_out_last;
    logic                        done;

    // Store incoming elements
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            a_mem[i_cmd.wr_addr] <= $unsigned(i_element);
        end
        if (i_cmd.wr_b) begin
            b_mem[i_cmd.wr_addr] <= $unsigned(i_element);
        end
    end

    // Read operand pair
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_a_q <= a_mem[i_cmd.a_addr];
            r_b_q <= b_mem[i_cmd.b_addr];
        end
    end

    // Low word of the product wraps as 32-bit arithmetic
    assign prod_low = imm_pkg::DATA_W'(r_a_q * r_b_q);
    assign sum      = (r_p2_first ? '0 : r_acc) + r_prod;
    assign done     = r_p2_valid && r_p2_last;

    // Carry tags and data down the pipe
    always_ff @(posedge i_clk) begin
        r_p1_first    <= i_cmd.first;
        r_p1_last     <= i_cmd.last;
        r_p1_last_run <= i_cmd.last_run;
        r_p1_row      <= i_cmd.row;
        r_p1_col      <= i_cmd.col;
        r_prod        <= prod_low;
        r_p2_first    <= r_p1_first;
        r_p2_last     <= r_p1_last;
        r_p2_last_run <= r_p1_last_run;
        r_p2_row      <= r_p1_row;
        r_p2_col      <= r_p1_col;
        if (r_p2_valid) begin
            r_acc <= sum;
        end
        if (done) begin
            r_out_value <= sum;
            r_out_row   <= r_p2_row;
            r_out_col   <= r_p2_col;
            r_out_last  <= r_p2_last_run;
        end
    end

    // Pipe valids and output hold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_p1_valid <= i_cmd.rd_en;
            r_p2_valid <= r_p1_valid;
            priority if (done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_busy = r_out_valid;
    assign o_stat.done     = done;

    assign o_out_valid     = r_out_valid;
    assign o_product_value = $signed(r_out_value);
    assign o_out_row       = r_out_row;
    assign o_out_col       = r_out_col;
    assign o_last_of_run   = r_out_last;

    `IMM_ASSERT(a_no_overwrite, i_clk, i_rst_n, done |-> !r_out_valid, "result loaded over a pending transaction")
    `IMM_ASSERT(a_load_when_drained, i_clk, i_rst_n, (i_cmd.wr_a || i_cmd.wr_b) |-> (!r_p1_valid && !r_p2_valid), "store written while products in flight")
    `IMM_ASSERT(a_one_access, i_clk, i_rst_n, $onehot0({i_cmd.wr_a, i_cmd.wr_b, i_cmd.rd_en}), "store write and read in one cycle")

endmodule

// ----- tb/product_checker.sv -----
module product_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [imm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [imm_pkg::DIM_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic signed [imm_pkg::DATA_W-1:0] i_element,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic signed [imm_pkg::DATA_W-1:0] i_product_value,
    input  logic [imm_pkg::IDX_W-1:0]         i_out_row,
    input  logic [imm_pkg::IDX_W-1:0]         i_out_col,
    input  logic                              i_last_of_run,
    output int                                o_fail_count,
    output int                                o_products_owed
);
    timeunit 1ns;
    timeprecision 1ps;
    import imm_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic              last;
    } product_t;

    // Shadow copy of the dimension registers and both matrix stores
    logic [DIM_W-1:0]  rows_a;
    logic [DIM_W-1:0]  inner_dim;
    logic [DIM_W-1:0]  cols_b;
    logic [DATA_W-1:0] a_elems [DEPTH];
    logic [DATA_W-1:0] b_elems [DEPTH];
    int                elems_loaded;
    product_t          owed_products [$];

    // Zero counts as one, anything past the largest size counts as the largest
    function automatic int dim_used(input logic [DIM_W-1:0] v);
        if (v == '0) return 1;
        if (v > DIM_W'(MAX_DIM)) return MAX_DIM;
        return int'(v);
    endfunction

    always @(posedge i_clk) begin : track
        int                r;
        int                k;
        int                c;
        int                a_len;
        int                total;
        logic [DATA_W-1:0] acc;
        product_t          want;
        if (!i_rst_n) begin
            rows_a       = DIM_W'(1);
            inner_dim    = DIM_W'(1);
            cols_b       = DIM_W'(1);
            elems_loaded = 0;
            o_fail_count = 0;
            owed_products.delete();
        end else begin
            // Compare an accepted result with the oldest predicted one
            if (i_out_valid && i_out_ready) begin
                if (owed_products.size() == 0) begin
                    $error("unexpected product: value %0d row %0d col %0d last %0b",
                           i_product_value, i_out_row, i_out_col, i_last_of_run);
                    o_fail_count++;
                end else begin
                    want = owed_products.pop_front();
                    if (i_product_value !== want.value) begin
                        $error("product_value mismatch: expected %0d, actual %0d",
                               $signed(want.value), i_product_value);
                        o_fail_count++;
                    end
                    if (i_out_row !== want.row) begin
                        $error("out_row mismatch: expected %0d, actual %0d",
                               want.row, i_out_row);
                        o_fail_count++;
                    end
                    if (i_out_col !== want.col) begin
                        $error("out_col mismatch: expected %0d, actual %0d",
                               want.col, i_out_col);
                        o_fail_count++;
                    end
                    if (i_last_of_run !== want.last) begin
                        $error("last_of_run mismatch: expected %0b, actual %0b",
                               want.last, i_last_of_run);
                        o_fail_count++;
                    end
                end
            end

            // Track register writes; any real register restarts loading
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ROWS_A: begin
                        rows_a       = i_cfg_data;
                        elems_loaded = 0;
                    end
                    CFG_INNER_DIM: begin
                        inner_dim    = i_cfg_data;
                        elems_loaded = 0;
                    end
                    CFG_COLS_B: begin
                        cols_b       = i_cfg_data;
                        elems_loaded = 0;
                    end
                    default: ;
                endcase
            end

            // Store an accepted element; on the last one of B predict the product
            if (i_in_valid && i_in_ready) begin
                r     = dim_used(rows_a);
                k     = dim_used(inner_dim);
                c     = dim_used(cols_b);
                a_len = r * k;
                total = a_len + k * c;
                if (elems_loaded >= total) elems_loaded = 0;
                if (elems_loaded < a_len) begin
                    a_elems[elems_loaded % DEPTH] = i_element;
                end else begin
                    b_elems[(elems_loaded - a_len) % DEPTH] = i_element;
                end
                elems_loaded++;
                if (elems_loaded >= total) begin
                    elems_loaded = 0;
                    for (int i = 0; i < r; i++) begin
                        for (int j = 0; j < c; j++) begin
                            acc = '0;
                            for (int t = 0; t < k; t++) begin
                                acc = acc + a_elems[(i * k + t) % DEPTH]
                                          * b_elems[(t * c + j) % DEPTH];
                            end
                            want.value = acc;
                            want.row   = IDX_W'(i);
                            want.col   = IDX_W'(j);
                            want.last  = (i == r - 1) && (j == c - 1);
                            owed_products.push_back(want);
                        end
                    end
                end
            end
        end
        o_products_owed = owed_products.size();
    end

endmodule

// ----- tb/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import imm_pkg::*;

    localparam int TOTAL_ITEMS    = 280;
    localparam int SETTLE_CYCLES  = 20;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_idx   = '0;
    logic [DIM_W-1:0]         cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic signed [DATA_W-1:0] element   = '0;
    logic                     out_ready = 1'b0;
    logic                     in_ready;
    logic                     out_valid;
    logic signed [DATA_W-1:0] product_value;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic                     last_of_run;

    int               fail_count;
    int               products_owed;
    int               sender_idle_pct    = 0;
    int               receiver_stall_pct = 0;
    bit               hold_request       = 1'b0;
    int               quiet_cycles       = 0;
    int               items_sent         = 0;
    int               phase              = 3;
    logic [DIM_W-1:0] cur_rows           = DIM_W'(1);
    logic [DIM_W-1:0] cur_inner          = DIM_W'(1);
    logic [DIM_W-1:0] cur_cols           = DIM_W'(1);
    logic [DIM_W-1:0] rand_rows          = DIM_W'(1);
    logic [DIM_W-1:0] rand_inner         = DIM_W'(1);
    logic [DIM_W-1:0] rand_cols          = DIM_W'(1);
    int               rand_len           = 0;
    int               rand_runs          = 0;

    always #6 clk = ~clk;

    integer_matrix_multiply dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_element       (element),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_product_value (product_value),
        .o_out_row       (out_row),
        .o_out_col       (out_col),
        .o_last_of_run   (last_of_run)
    );

    product_checker u_product_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_element       (element),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_product_value (product_value),
        .i_out_row       (out_row),
        .i_out_col       (out_col),
        .i_last_of_run   (last_of_run),
        .o_fail_count    (fail_count),
        .o_products_owed (products_owed)
    );

    // Abort when no transaction moves on either channel for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (rst_n) begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    function automatic int clamp_dim(input logic [DIM_W-1:0] v);
        return (v == '0) ? 1 : ((v > DIM_W'(MAX_DIM)) ? MAX_DIM : int'(v));
    endfunction

    function automatic logic [DATA_W-1:0] pick_element();
        logic [DATA_W-1:0] v;
        case ($urandom_range(9))
            0:       v = 32'h7FFF_FFFF;
            1:       v = 32'h8000_0000;
            2:       v = '1;
            3:       v = '0;
            4:       v = DATA_W'($urandom_range(16)) - DATA_W'(8);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Mostly small sizes, now and then zero or the largest size and above
    function automatic logic [DIM_W-1:0] pick_dim();
        logic [DIM_W-1:0] v;
        case ($urandom_range(9))
            0:       v = '0;
            1:       v = DIM_W'($urandom_range(15, 8));
            default: v = DIM_W'($urandom_range(4, 1));
        endcase
        return v;
    endfunction

    task automatic set_mode(input int mode);
        case (mode)
            1:       begin sender_idle_pct = 66; receiver_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  receiver_stall_pct = 66; end
            3:       begin sender_idle_pct = 7;  receiver_stall_pct = 7;  end
            default: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        endcase
    endtask

    // Offer one element, idling first at random, and hold it until accepted
    task automatic push_element(input logic [DATA_W-1:0] v);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        element  <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    // Send whole matrix pairs for the current dimensions
    task automatic send_runs(input int runs);
        int n;
        n = clamp_dim(cur_rows) * clamp_dim(cur_inner)
          + clamp_dim(cur_inner) * clamp_dim(cur_cols);
        repeat (runs * n) push_element(pick_element());
        in_valid <= 1'b0;
    endtask

    // Write all three dimensions on back-to-back cycles, optionally the spare index too
    task automatic set_dims(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] k,
                            input logic [DIM_W-1:0] c, input bit spare);
        cur_rows  = r;
        cur_inner = k;
        cur_cols  = c;
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_ROWS_A;
        cfg_data <= r;
        @(posedge clk);
        cfg_idx  <= CFG_INNER_DIM;
        cfg_data <= k;
        @(posedge clk);
        cfg_idx  <= CFG_COLS_B;
        cfg_data <= c;
        @(posedge clk);
        if (spare) begin
            cfg_idx  <= CFG_SPARE;
            cfg_data <= DIM_W'($urandom_range(15));
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Wait until every predicted product has come out, then let the block go quiet
    task automatic settle();
        @(negedge clk);
        while (products_owed != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        @(posedge clk);
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset dimensions are 1 x 1: extreme operands, then all ones squared
        push_element(32'h7FFF_FFFF);
        push_element(32'h8000_0000);
        push_element('1);
        push_element('1);
        in_valid <= 1'b0;
        settle();

        // Zero sizes clamp up to one, oversized columns clamp down to eight
        set_dims(DIM_W'(0), DIM_W'(0), DIM_W'(15), 1'b1);
        send_runs(1);
        settle();

        // Drop a partial load by rewriting the registers mid-run
        set_dims(DIM_W'(2), DIM_W'(2), DIM_W'(2), 1'b0);
        repeat (3) push_element(pick_element());
        in_valid <= 1'b0;
        settle();
        set_dims(DIM_W'(2), DIM_W'(2), DIM_W'(2), 1'b0);
        send_runs(1);
        settle();

        // Widest product: a full set of 64 results from 8 x 1 times 1 x 8
        set_mode(1);
        set_dims(DIM_W'(8), DIM_W'(1), DIM_W'(8), 1'b0);
        send_runs(1);
        settle();

        // Longest dot product
        set_mode(2);
        set_dims(DIM_W'(1), DIM_W'(8), DIM_W'(1), 1'b0);
        send_runs(2);
        settle();

        // Hold off the receiver while the sender keeps offering back-to-back runs
        set_mode(0);
        set_dims(DIM_W'(4), DIM_W'(4), DIM_W'(4), 1'b0);
        hold_request = 1'b1;
        send_runs(2);
        settle();

        // Random phases, cycling through the idling patterns; shrink the tail to fit the count
        while (items_sent < TOTAL_ITEMS) begin
            set_mode(phase % 4);
            rand_rows  = pick_dim();
            rand_inner = pick_dim();
            rand_cols  = pick_dim();
            rand_len   = clamp_dim(rand_rows) * clamp_dim(rand_inner)
                       + clamp_dim(rand_inner) * clamp_dim(rand_cols);
            if (items_sent + rand_len > TOTAL_ITEMS) begin
                rand_rows  = DIM_W'(1);
                rand_inner = DIM_W'(1);
                rand_cols  = DIM_W'(1);
                rand_len   = 2;
            end
            rand_runs = $urandom_range(3, 1);
            while (rand_runs > 1 && items_sent + rand_runs * rand_len > TOTAL_ITEMS) begin
                rand_runs--;
            end
            set_dims(rand_rows, rand_inner, rand_cols, $urandom_range(3) == 0);
            send_runs(rand_runs);
            settle();
            phase++;
        end

        if (fail_count == 0 && products_owed == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
